// File: src/gelu_pkg.sv
// ============================================================================
// gelu_pkg: shared constants for the tanh-approximated GELU pipeline
// Fixed-point formats and coefficients used by the pipeline sections.
// ============================================================================
`default_nettype none

package gelu_pkg;

  // Clamp point of |x| for the sigmoid argument, in whole units
  localparam int unsigned CLAMP_INT = 8;

  // Front-end formats
  localparam int unsigned A16_W  = 20;  // |x| clamped, Q16, at most 2^19
  localparam int unsigned X2_W   = 23;  // x^2 in Q16
  localparam int unsigned T_W    = 20;  // 2*sqrt(2/pi)*|x| in Q16
  localparam int unsigned POLY_W = 26;  // 1 + 0.044715*x^2 in Q24
  localparam int unsigned M_W    = 22;  // |z| in Q16

  // Coefficients in Q24
  localparam logic [24:0] K_SCALE_Q24 = 25'd26772563;
  localparam logic [19:0] K_CUBIC_Q24 = 20'd750193;

  // Exponential: range reduction and series
  localparam int unsigned R_W    = 30;              // reduced argument, Q30
  localparam int unsigned ACC_W  = 31;              // series value, Q30, up to 1.0
  localparam int unsigned E_W    = ACC_W;           // exp(-|z|), Q30
  localparam int unsigned N_W    = 7;               // count of ln2 steps
  localparam int unsigned EXP_TERMS = 10;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [16:0] N_RECIP   = 17'd94548;    // floor(2^46 / LN2_Q30)
  localparam int unsigned N_RECIP_SHIFT = 32;
  localparam logic [ACC_W-1:0] Q30_ONE = 31'h4000_0000;

  // Sigmoid division
  localparam int unsigned S_W   = 31;  // sigmoid, Q30, up to 1.0
  localparam int unsigned DEN_W = 32;  // 1 + e, Q30
  localparam int unsigned NUM_W = 61;  // numerator, Q60 plus rounding term

endpackage

`default_nettype wire

// File: src/gelu_tanh_activation.sv
// ============================================================================
// gelu_tanh_activation: streaming tanh-approximated GELU on signed fixed point
// Throughput: one beat per cycle; the whole pipeline holds while the output
// beat waits, so input ready follows output ready while an output beat is held.
// Depth is set by the 31-stage sigmoid divider and the 20-stage exp series.
// Reset clears all valid bits; the block is stateless otherwise.
// ============================================================================
`default_nettype none

module gelu_tanh_activation import gelu_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tdata: [DATA_WIDTH-1:0] sample_in, rest zero
  input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  input  wire logic                              s_axis_tlast_i,   // last_in
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // tdata: [DATA_WIDTH-1:0] gelu_out, rest zero
  output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata_o,
  output logic                                   m_axis_tlast_o    // last_out
);

  localparam int TDATA_W = ((DATA_WIDTH+7)/8)*8;
  localparam int SIDE_W  = DATA_WIDTH + 2;
  localparam int PROD_W  = DATA_WIDTH + S_W;
  localparam logic [DATA_WIDTH:0] POS_LIM = {2'b00, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH:0] NEG_LIM = {2'b01, {(DATA_WIDTH-1){1'b0}}};

  logic                  en;
  logic                  poly_v;
  logic [M_W-1:0]        poly_m;
  logic [SIDE_W-1:0]     poly_side;
  logic                  exp_v;
  logic [E_W-1:0]        exp_e;
  logic [SIDE_W-1:0]     exp_side;
  logic                  div_v;
  logic [S_W-1:0]        div_s;
  logic [SIDE_W-1:0]     div_side;

  logic                  fin_v_q;
  logic [PROD_W-1:0]     prod_q;
  logic                  fin_neg_q;
  logic                  fin_last_q;
  logic [PROD_W-1:0]     rnd_sum;
  logic [DATA_WIDTH:0]   rnd;
  logic [DATA_WIDTH:0]   lim;
  logic [DATA_WIDTH-1:0] res;

  logic                  out_v_q;
  logic [DATA_WIDTH-1:0] out_data_q;
  logic                  out_last_q;
  logic                  out_neg_q;

  // Advance everything unless a finished beat is stuck at the output
  assign en              = m_axis_tready_i || !out_v_q;
  assign s_axis_tready_o = en;

  gelu_poly #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_poly (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid_i),
    .sample_i (s_axis_tdata_i[DATA_WIDTH-1:0]),
    .last_i   (s_axis_tlast_i),
    .valid_o  (poly_v),
    .m_o      (poly_m),
    .side_o   (poly_side)
  );

  gelu_exp #(
    .SIDE_W (SIDE_W)
  ) u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (poly_v),
    .m_i     (poly_m),
    .side_i  (poly_side),
    .valid_o (exp_v),
    .e_o     (exp_e),
    .side_o  (exp_side)
  );

  gelu_div #(
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (exp_v),
    .e_i     (exp_e),
    .neg_i   (exp_side[DATA_WIDTH]),
    .side_i  (exp_side),
    .valid_o (div_v),
    .s_o     (div_s),
    .side_o  (div_side)
  );

  // Round |y| = |x| * s, saturate and apply the sign
  assign rnd_sum = prod_q + (PROD_W'(1) << 29);
  assign rnd     = (DATA_WIDTH+1)'(rnd_sum >> 30);
  assign lim     = fin_neg_q ? ((rnd > NEG_LIM) ? NEG_LIM : rnd)
                             : ((rnd > POS_LIM) ? POS_LIM : rnd);
  assign res     = fin_neg_q ? DATA_WIDTH'(-lim) : DATA_WIDTH'(lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      fin_v_q <= div_v;
      out_v_q <= fin_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q     <= PROD_W'(div_side[DATA_WIDTH-1:0]) * PROD_W'(div_s);
      fin_neg_q  <= div_side[DATA_WIDTH];
      fin_last_q <= div_side[DATA_WIDTH+1];
      out_data_q <= res;
      out_neg_q  <= fin_neg_q;
      out_last_q <= fin_last_q;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = TDATA_W'(out_data_q);
  assign m_axis_tlast_o  = out_last_q;

  // Exponential never exceeds 1.0
  a_exp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_v |-> (exp_e <= Q30_ONE))
    else $error("exp result above 1.0");

  // Sigmoid quotient never exceeds 1.0
  a_sig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v |-> (div_s <= S_W'(Q30_ONE)))
    else $error("sigmoid above 1.0");

  // A waiting output beat stalls the input side
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while output stalled");

  // Result keeps the sign of the sample
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_neg_q ? (out_data_q[DATA_WIDTH-1] || (out_data_q == '0))
                                   : !out_data_q[DATA_WIDTH-1]))
    else $error("result sign differs from sample sign");

endmodule

`default_nettype wire

// File: src/gelu_poly.sv
// ============================================================================
// gelu_poly: magnitude, clamp and sigmoid argument
// Four stages: sign/magnitude and clamp to Q16, x^2 and scaled x, the cubic
// term, then |z| = t * poly.
// ============================================================================
`default_nettype none

module gelu_poly import gelu_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [DATA_WIDTH-1:0] sample_i,
  input  wire logic                  last_i,
  output logic                       valid_o,
  output logic [M_W-1:0]             m_o,
  output logic [DATA_WIDTH+1:0]      side_o   // {last, neg, mag}
);

  localparam int SIDE_W = DATA_WIDTH + 2;
  localparam logic [32:0] BOUND = 33'(CLAMP_INT) << FRAC_BITS;

  logic                  neg;
  logic [DATA_WIDTH-1:0] mag;
  logic [32:0]           mag_x;
  logic [32:0]           a_c;
  logic [A16_W-1:0]      a16;
  logic [39:0]           sq_prod;
  logic [44:0]           t_prod;
  logic [42:0]           cub_prod;
  logic [45:0]           m_prod;

  logic [3:0]            valid_q;
  logic [A16_W-1:0]      a16_q;
  logic [X2_W-1:0]       x2_q;
  logic [T_W-1:0]        t2_q;
  logic [T_W-1:0]        t3_q;
  logic [POLY_W-1:0]     poly_q;
  logic [M_W-1:0]        m_q;
  logic [SIDE_W-1:0]     side_q [4];

  // Sign, magnitude and clamp
  assign neg   = sample_i[DATA_WIDTH-1];
  assign mag   = neg ? (~sample_i + 1'b1) : sample_i;
  assign mag_x = 33'(mag);
  assign a_c   = (mag_x < BOUND) ? mag_x : BOUND;

  // Bring the clamped value to Q16
  if (FRAC_BITS <= 16) begin : g_up
    assign a16 = A16_W'(a_c << (16 - FRAC_BITS));
  end else begin : g_dn
    assign a16 = A16_W'((a_c + (33'd1 << (FRAC_BITS - 17))) >> (FRAC_BITS - 16));
  end

  assign sq_prod  = 40'(a16_q) * 40'(a16_q);
  assign t_prod   = 45'(a16_q) * 45'(K_SCALE_Q24);
  assign cub_prod = 43'(x2_q) * 43'(K_CUBIC_Q24);
  assign m_prod   = 46'(t3_q) * 46'(poly_q);

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a16_q     <= a16;
      side_q[0] <= {last_i, neg, mag};
      x2_q      <= X2_W'(sq_prod >> 16);
      t2_q      <= T_W'(t_prod >> 24);
      side_q[1] <= side_q[0];
      poly_q    <= POLY_W'(26'd1 << 24) + POLY_W'(cub_prod >> 16);
      t3_q      <= t2_q;
      side_q[2] <= side_q[1];
      m_q       <= M_W'(m_prod >> 24);
      side_q[3] <= side_q[2];
    end
  end

  assign valid_o = valid_q[3];
  assign m_o     = m_q;
  assign side_o  = side_q[3];

endmodule

`default_nettype wire

// File: src/gelu_exp.sv
// ============================================================================
// gelu_exp: exp(-|z|) in Q30
// Range reduction by ln2 over three stages, a ten-term Horner series at two
// stages per term, then the shift by the ln2 count.
// ============================================================================
`default_nettype none

module gelu_exp import gelu_pkg::*; #(
  parameter int SIDE_W = 18
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [M_W-1:0]    m_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [E_W-1:0]         e_o,
  output logic [SIDE_W-1:0]      side_o
);

  // Range reduction
  logic [38:0]       nest_prod;
  logic [35:0]       m30;
  logic [36:0]       nl_prod;
  logic [36:0]       r0_full;
  logic              r_ge;
  logic [N_W-1:0]    n_inc;

  logic [1:0]        red_v_q;
  logic [M_W-1:0]    m1_q;
  logic [N_W-1:0]    nest1_q;
  logic [N_W-1:0]    nest2_q;
  logic [R_W:0]      r0_q;
  logic [SIDE_W-1:0] red_side_q [2];

  // Horner chain: index 0 is loaded by range reduction
  logic              hv_q    [EXP_TERMS+1];
  logic [ACC_W-1:0]  acc_q   [EXP_TERMS+1];
  logic [R_W-1:0]    hr_q    [EXP_TERMS+1];
  logic [4:0]        hn_q    [EXP_TERMS+1];
  logic              hz_q    [EXP_TERMS+1];
  logic [SIDE_W-1:0] hside_q [EXP_TERMS+1];

  logic              av_q    [EXP_TERMS];
  logic [R_W-1:0]    av_val_q[EXP_TERMS];
  logic [R_W-1:0]    ar_q    [EXP_TERMS];
  logic [4:0]        an_q    [EXP_TERMS];
  logic              az_q    [EXP_TERMS];
  logic [SIDE_W-1:0] aside_q [EXP_TERMS];

  logic              e_v_q;
  logic [E_W-1:0]    e_q;
  logic [SIDE_W-1:0] e_side_q;

  assign nest_prod = 39'(m_i) * 39'(N_RECIP);
  assign m30       = {m1_q, 14'b0};
  assign nl_prod   = 37'(nest1_q) * 37'(LN2_Q30);
  assign r0_full   = 37'(m30) - nl_prod;
  assign r_ge      = (r0_q >= 31'(LN2_Q30));
  assign n_inc     = nest2_q + N_W'(r_ge);

  // Advance range-reduction valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_v_q <= '0;
      hv_q[0] <= 1'b0;
    end else if (en_i) begin
      red_v_q <= {red_v_q[0], valid_i};
      hv_q[0] <= red_v_q[1];
    end
  end

  // Estimate the ln2 count, take the remainder, correct by one step
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q          <= m_i;
      nest1_q       <= N_W'(nest_prod >> N_RECIP_SHIFT);
      red_side_q[0] <= side_i;
      nest2_q       <= nest1_q;
      r0_q          <= (R_W+1)'(r0_full);
      red_side_q[1] <= red_side_q[0];
      acc_q[0]      <= Q30_ONE;
      hr_q[0]       <= r_ge ? R_W'(r0_q - 31'(LN2_Q30)) : R_W'(r0_q);
      hn_q[0]       <= n_inc[4:0];
      hz_q[0]       <= (n_inc[N_W-1:5] != '0);
      hside_q[0]    <= red_side_q[1];
    end
  end

  // One series term per pair of stages: acc = 1 - (r * acc) / k
  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
    localparam int unsigned K = EXP_TERMS - j;
    localparam int unsigned L = $clog2(K);
    localparam logic [63:0] MAGIC = ((64'd1 << (30 + L)) + 64'(K) - 64'd1) / 64'(K);

    logic [60:0] ra_prod;
    logic [60:0] q_prod;

    assign ra_prod = 61'(hr_q[j]) * 61'(acc_q[j]);
    assign q_prod  = 61'(av_val_q[j]) * 61'(MAGIC[30:0]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        av_q[j]   <= 1'b0;
        hv_q[j+1] <= 1'b0;
      end else if (en_i) begin
        av_q[j]   <= hv_q[j];
        hv_q[j+1] <= av_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        av_val_q[j]  <= R_W'(ra_prod >> 30);
        ar_q[j]      <= hr_q[j];
        an_q[j]      <= hn_q[j];
        az_q[j]      <= hz_q[j];
        aside_q[j]   <= hside_q[j];
        acc_q[j+1]   <= Q30_ONE - ACC_W'(q_prod >> (30 + L));
        hr_q[j+1]    <= ar_q[j];
        hn_q[j+1]    <= an_q[j];
        hz_q[j+1]    <= az_q[j];
        hside_q[j+1] <= aside_q[j];
      end
    end
  end

  // Scale by 2^-n, drop to zero past 31 steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (en_i) begin
      e_v_q <= hv_q[EXP_TERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q      <= hz_q[EXP_TERMS] ? '0 : (acc_q[EXP_TERMS] >> hn_q[EXP_TERMS]);
      e_side_q <= hside_q[EXP_TERMS];
    end
  end

  assign valid_o = e_v_q;
  assign e_o     = e_q;
  assign side_o  = e_side_q;

endmodule

`default_nettype wire

// File: src/gelu_div.sv
// ============================================================================
// gelu_div: sigmoid by restoring division
// Forms 1 + e and the rounded numerator, then one quotient bit per stage.
// ============================================================================
`default_nettype none

module gelu_div import gelu_pkg::*; #(
  parameter int SIDE_W = 18
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [E_W-1:0]    e_i,
  input  wire logic              neg_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [S_W-1:0]         s_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] num;

  logic              v_q    [S_W+1];
  logic [DEN_W-1:0]  den_q  [S_W+1];
  logic [S_W-1:0]    rem_q  [S_W+1];
  logic [S_W-1:0]    low_q  [S_W+1];
  logic [S_W-1:0]    quo_q  [S_W+1];
  logic [SIDE_W-1:0] side_q [S_W+1];

  // Denominator and numerator with the half-divisor rounding term
  assign den = DEN_W'(Q30_ONE) + DEN_W'(e_i);
  assign num = (neg_i ? (NUM_W'(e_i) << 30) : (NUM_W'(1) << 60)) + NUM_W'(den >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den;
      rem_q[0]  <= S_W'(num[NUM_W-1:S_W]);
      low_q[0]  <= num[S_W-1:0];
      quo_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar i = 0; i < S_W; i++) begin : g_bit
    logic [DEN_W-1:0] trial;
    logic             ge;

    assign trial = {rem_q[i], low_q[i][S_W-1-i]};
    assign ge    = (trial >= den_q[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= ge ? S_W'(trial - den_q[i]) : S_W'(trial);
        quo_q[i+1]  <= quo_q[i] | (S_W'(ge) << (S_W-1-i));
        den_q[i+1]  <= den_q[i];
        low_q[i+1]  <= low_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = v_q[S_W];
  assign s_o     = quo_q[S_W];
  assign side_o  = side_q[S_W];

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream-level check of the tanh-approximated GELU pipeline
// Drives Q4.12 samples with random gaps and output stalls, predicts each
// result with an integer GELU model and compares beats in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import gelu_pkg::*;

  localparam int DW = 16;
  localparam int FB = 12;
  localparam int LATENCY = 62;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [DW-1:0] sample;
    logic          last;
  } beat_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_axis_tvalid_i = 1'b0;
  logic           s_axis_tready_o;
  logic [DW-1:0]  s_axis_tdata_i = '0;   // [15:0] sample_in
  logic           s_axis_tlast_i = 1'b0; // last_in
  logic           m_axis_tvalid_o;
  logic           m_axis_tready_i = 1'b0;
  logic [DW-1:0]  m_axis_tdata_o;        // [15:0] gelu_out
  logic           m_axis_tlast_o;        // last_out

  beat_t pending_q[$];
  beat_t gelu_exp_q[$];
  int    drain_hold = -1;   // while 0: hold off until results drain
  int    errors = 0;
  int    cycles = 0;
  bit    stim_done = 1'b0;
  int    tx_gap = 0;
  int    rx_gap = 0;

  gelu_tanh_activation #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (.*);

  always #5 clk_i = ~clk_i;

  // exp(-m) with m in Q16, result in Q30
  function automatic logic [63:0] exp_neg(logic [63:0] m16);
    logic [63:0] m30, n, r, acc;
    m30 = m16 << 14;
    n = m30 / 64'(LN2_Q30);
    r = m30 - n * 64'(LN2_Q30);
    acc = 64'd1 << 30;
    for (int k = EXP_TERMS; k >= 1; k--)
      acc = (64'd1 << 30) - ((r * acc) >> 30) / 64'(k);
    return (n > 31) ? 64'd0 : (acc >> n);
  endfunction

  function automatic beat_t gelu_predict(beat_t in_b);
    beat_t       res;
    logic        neg;
    logic [63:0] mag, a, a16, x2, poly, t, m, e, den, s, prod;
    neg = in_b.sample[DW-1];
    mag = neg ? ((64'd1 << DW) - 64'(in_b.sample)) : 64'(in_b.sample);
    a = (mag < (64'(CLAMP_INT) << FB)) ? mag : (64'(CLAMP_INT) << FB);
    a16 = a << (16 - FB);
    x2 = (a16 * a16) >> 16;
    poly = (64'd1 << 24) + ((64'(K_CUBIC_Q24) * x2) >> 16);
    t = (a16 * 64'(K_SCALE_Q24)) >> 24;
    m = (t * poly) >> 24;
    e = exp_neg(m);
    den = (64'd1 << 30) + e;
    s = neg ? (((e << 30) + den / 2) / den) : (((64'd1 << 60) + den / 2) / den);
    prod = (mag * s + (64'd1 << 29)) >> 30;
    if (neg) begin
      if (prod > (64'd1 << (DW - 1))) prod = 64'd1 << (DW - 1);
      res.sample = DW'(64'd0 - prod);
    end else begin
      if (prod > (64'd1 << (DW - 1)) - 1) prod = (64'd1 << (DW - 1)) - 1;
      res.sample = DW'(prod);
    end
    res.last = in_b.last;
    return res;
  endfunction

  // Fill the stimulus queue: directed corners, then random
  initial begin
    beat_t b;
    logic [DW-1:0] dir[$] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                              16'h8001, 16'h7FFE, 16'h1000, 16'hF000, 16'h8000 >> 1,
                              16'h7FFF - 16'h7FFF + 16'h0800, 16'hF800, 16'h2000,
                              16'hE000, 16'h6000, 16'hA000, 16'h5555, 16'hAAAA};
    foreach (dir[i]) begin
      b.sample = dir[i];
      b.last = (i % 3) == 2;
      pending_q.push_back(b);
    end
    for (int i = 0; i < 1800; i++) begin
      case ($urandom_range(0, 3))
        0: b.sample = DW'($urandom);
        1: b.sample = DW'($signed($urandom_range(0, 24576)) - 12288);
        2: b.sample = DW'($signed($urandom_range(0, 4096)) - 2048);
        default: b.sample = DW'($urandom_range(0, 1) ? 16'h7FFF - $urandom_range(0, 8)
                                                     : 16'h8000 + $urandom_range(0, 8));
      endcase
      b.last = ($urandom_range(0, 7) == 0);
      pending_q.push_back(b);
    end
  end

  // Hold reset, then release it
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: present beats with random gaps; hold once until results drain
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        gelu_exp_q.push_back(gelu_predict('{s_axis_tdata_i, s_axis_tlast_i}));
        pending_q.pop_front();
        tx_gap = $urandom_range(0, 3);
        if (pending_q.size() == 900 && drain_hold < 0) drain_hold = 0;
      end
      if (drain_hold == 0 && gelu_exp_q.size() == 0) drain_hold = 1;
      if (pending_q.size() == 0) begin
        s_axis_tvalid_i <= 1'b0;
        stim_done = 1'b1;
      end else if (drain_hold == 0) begin
        s_axis_tvalid_i <= 1'b0;
      end else if (tx_gap > 0 && !(s_axis_tvalid_i && !s_axis_tready_o)) begin
        tx_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= pending_q[0].sample;
        s_axis_tlast_i  <= pending_q[0].last;
      end
    end
  end

  // Monitor: compare each output beat with the oldest prediction
  always @(posedge clk_i) begin
    beat_t exp_b;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (gelu_exp_q.size() == 0) begin
          $display("%0t: unexpected beat data=%h last=%b", $time,
                   m_axis_tdata_o, m_axis_tlast_o);
          errors++;
        end else begin
          exp_b = gelu_exp_q.pop_front();
          if (m_axis_tdata_o !== exp_b.sample) begin
            $display("%0t: gelu_out expected %h actual %h", $time,
                     exp_b.sample, m_axis_tdata_o);
            errors++;
          end
          if (m_axis_tlast_o !== exp_b.last) begin
            $display("%0t: last_out expected %b actual %b", $time,
                     exp_b.last, m_axis_tlast_o);
            errors++;
          end
        end
        rx_gap = $urandom_range(0, 3);
      end
      // Stall in bursts, with stretches of free flow
      if (rx_gap > 0 && ((cycles / 2000) % 3 != 2)) begin
        rx_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // End of run and timeout
  initial begin
    while (!(stim_done && gelu_exp_q.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("gelu_tanh_activation: mismatch");
    end else begin
      repeat (LATENCY * 2) @(posedge clk_i);
      if (errors == 0) begin
        $display("gelu_tanh_activation: match");
      end else begin
        $display("gelu_tanh_activation: mismatch");
      end
    end
    $finish;
  end

endmodule
